// ===== design/ssp_pkg.sv =====
// shared types and constants for the shortest path unit
`timescale 1ns / 1ps
package ssp_pkg;

  localparam int DIST_BITS = 22;
  localparam int IDX_BITS  = 6;
  localparam logic [DIST_BITS-1:0] DIST_MAX = 22'h3FFFFF;
  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_SOLVE = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD1,
    ST_ADD_WR1,
    ST_ADD_RD2,
    ST_ADD_WR2,
    ST_INIT,
    ST_RELAX,
    ST_OUT
  } state_t;

  // per-vertex record that travels round the ring of cells
  typedef struct packed {
    logic [DIST_BITS-1:0] dist_val;
    logic [IDX_BITS-1:0]  parent;
    logic                 done;
    logic                 reached;
  } vrec_t;

  // control for the relax and select stage
  typedef struct packed {
    logic                 active;
    logic                 is_cur;
    logic                 best_found;
    logic [DIST_BITS-1:0] best_dist;
  } rx_ctl_t;

endpackage

// ===== design/ssp_ram.sv =====
// generic single port ram with registered read
`timescale 1ns / 1ps
module ssp_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/ssp_cell.sv =====
// one ring cell holding the record of one vertex
`timescale 1ns / 1ps
module ssp_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  ssp_pkg::vrec_t d,
  output ssp_pkg::vrec_t q
);
  import ssp_pkg::*;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q <= d;
    end
  end

endmodule

// ===== design/ssp_relax.sv =====
// relaxes the record at the ring head and checks it as next pick
`timescale 1ns / 1ps
module ssp_relax #(
  parameter int WEIGHT_BITS = 16
) (
  input  ssp_pkg::vrec_t                  head,
  input  logic [WEIGHT_BITS:0]            edge_word,
  input  logic [ssp_pkg::DIST_BITS-1:0]   cur_dist,
  input  logic [ssp_pkg::IDX_BITS-1:0]    cur_idx,
  input  ssp_pkg::rx_ctl_t                ctl,
  output ssp_pkg::vrec_t                  upd,
  output logic                            pick
);
  import ssp_pkg::*;

  localparam int SW = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;

  logic [SW-1:0]        cand;
  logic [DIST_BITS-1:0] cand_sat;
  logic                 present;

  assign present  = edge_word[WEIGHT_BITS];
  assign cand     = SW'(cur_dist) + SW'(edge_word[WEIGHT_BITS-1:0]);
  assign cand_sat = (cand > SW'(DIST_MAX)) ? DIST_MAX : cand[DIST_BITS-1:0];

  always_comb begin
    upd = head;
    if (ctl.active && present && (!head.reached || cand_sat < head.dist_val)) begin
      upd.dist_val = cand_sat;
      upd.parent   = cur_idx;
      upd.reached  = 1'b1;
    end
    if (ctl.is_cur) begin
      upd.done = 1'b1;
    end
    // strict compare keeps the lowest index on a tie
    pick = ctl.active && !upd.done && upd.reached &&
           (!ctl.best_found || upd.dist_val < ctl.best_dist);
  end

endmodule

// ===== design/single_source_shortest_paths_unit.sv =====
// top level of the dense-graph shortest path unit
// usage:
// - config port (apb style): register 0 at address 0 is vertex_count, 1 to 64
// - item channel (item_valid/item_ready): command add edge, solve or clear;
//   a word is taken only while the unit is idle
// - result channel (result_valid/result_ready): a solve gives one word per
//   vertex in index order, last_flag on the final one
// operation:
// - add edge: read-modify-write of the edge ram (one port), in one
//   direction if directed, in both if undirected
// - solve: an initial sweep of the ring of cells, one relax sweep per
//   settled vertex, then an output sweep
// - clear: one edge ram entry per cycle over the whole edge ram
//   (4096 entries by default)
// reset clears the edge ram by the same pass before the first item is taken
// a stalled receiver holds the output sweep; results are never dropped
`timescale 1ns / 1ps
module single_source_shortest_paths_unit #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  command,
  input  logic [5:0]  src_vertex,
  input  logic [5:0]  dst_vertex,
  input  logic [15:0] edge_weight,
  input  logic        directed,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [5:0]  vertex_index,
  output logic [21:0] path_distance,
  output logic [5:0]  parent_vertex,
  output logic        parent_valid,
  output logic        reachable,
  output logic        last_flag
);
  import ssp_pkg::*;

  localparam int VB    = $clog2(MAX_VERTICES);
  localparam int AB    = 2 * VB;
  localparam int DEPTH = 1 << AB;
  localparam int EW    = WEIGHT_BITS + 1;

  state_t state, state_next;

  logic [6:0]             vcount;
  logic [6:0]             nv;
  logic [5:0]             a_r, b_r, start;
  logic [WEIGHT_BITS-1:0] w_r;
  logic                   dir_r;
  logic [VB-1:0]          cur;
  logic [DIST_BITS-1:0]   cur_dist;
  logic [VB:0]            kcnt, jm1;
  logic [AB-1:0]          clr_cnt;
  logic                   best_found;
  logic [VB-1:0]          best_idx;
  logic [DIST_BITS-1:0]   best_dist;
  logic                   start_ok, accept, adv, has_parent, put;

  logic          ram_we;
  logic [AB-1:0] ram_addr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic   shift_en, out_load, pick;
  vrec_t  ring [MAX_VERTICES];
  vrec_t  head, tail, upd;
  rx_ctl_t rx_ctl;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {25'd0, vcount} : 32'd0;

  assign nv = (vcount == 7'd0) ? 7'd1 :
              (vcount > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vcount;
  assign start_ok   = 7'(start) < nv;
  assign accept     = item_valid && item_ready;
  assign jm1        = kcnt - 1'b1;
  assign head       = ring[0];
  assign adv        = (7'(kcnt) >= nv) || !result_valid || result_ready;
  assign has_parent = head.reached && (6'(kcnt) != start);
  assign put        = !ram_rdata[WEIGHT_BITS] || (w_r < ram_rdata[WEIGHT_BITS-1:0]);

  assign rx_ctl.active     = (state == ST_RELAX) && (kcnt != '0) && (7'(jm1) < nv);
  assign rx_ctl.is_cur     = (jm1[VB-1:0] == cur);
  assign rx_ctl.best_found = best_found;
  assign rx_ctl.best_dist  = best_dist;

  ssp_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_edges (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  ssp_relax #(.WEIGHT_BITS(WEIGHT_BITS)) u_relax (
    .head(head), .edge_word(ram_rdata), .cur_dist(cur_dist),
    .cur_idx(6'(cur)), .ctl(rx_ctl), .upd(upd), .pick(pick)
  );

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_ring
    if (i == MAX_VERTICES - 1) begin : g_last
      ssp_cell u_cell (.clk(clk), .shift_en(shift_en), .d(tail), .q(ring[i]));
    end else begin : g_mid
      ssp_cell u_cell (.clk(clk), .shift_en(shift_en), .d(ring[i+1]), .q(ring[i]));
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == '1) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (command)
            CMD_ADD: begin
              if (7'(src_vertex) < 7'(MAX_VERTICES) && 7'(dst_vertex) < 7'(MAX_VERTICES))
                state_next = ST_ADD_RD1;
            end
            CMD_SOLVE: state_next = ST_INIT;
            CMD_CLEAR: state_next = ST_CLEAR;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD_RD1: state_next = ST_ADD_WR1;
      ST_ADD_WR1: state_next = dir_r ? ST_IDLE : ST_ADD_RD2;
      ST_ADD_RD2: state_next = ST_ADD_WR2;
      ST_ADD_WR2: state_next = ST_IDLE;
      ST_INIT: begin
        if (kcnt == (VB+1)'(MAX_VERTICES - 1)) state_next = start_ok ? ST_RELAX : ST_OUT;
      end
      ST_RELAX: begin
        // the last vertex of the sweep can still be the pick
        if (kcnt == (VB+1)'(MAX_VERTICES) && !best_found && !pick) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (adv && kcnt == (VB+1)'(MAX_VERTICES - 1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_ready = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = {a_r[VB-1:0], b_r[VB-1:0]};
    ram_wdata  = {1'b1, w_r};
    shift_en   = 1'b0;
    tail       = head;
    out_load   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt;
        ram_wdata = '0;
      end
      ST_IDLE:    item_ready = 1'b1;
      ST_ADD_RD1: ;
      ST_ADD_WR1: ram_we = put;
      ST_ADD_RD2: ram_addr = {b_r[VB-1:0], a_r[VB-1:0]};
      ST_ADD_WR2: begin
        ram_addr = {b_r[VB-1:0], a_r[VB-1:0]};
        ram_we   = put;
      end
      ST_INIT: begin
        shift_en      = 1'b1;
        tail.dist_val = '0;
        tail.parent   = '0;
        tail.reached  = start_ok && (kcnt[VB-1:0] == start[VB-1:0]);
        tail.done     = start_ok && (kcnt[VB-1:0] == start[VB-1:0]);
      end
      ST_RELAX: begin
        // edge word for vertex k arrives in the cycle after its address
        ram_addr = {cur, kcnt[VB-1:0]};
        shift_en = (kcnt != '0);
        tail     = upd;
      end
      ST_OUT: begin
        shift_en = adv;
        out_load = adv && (7'(kcnt) < nv);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      vcount       <= 7'd64;
      clr_cnt      <= '0;
      kcnt         <= '0;
      best_found   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (psel && penable && pwrite && paddr[2] == REG_VERTEX_COUNT) begin
        vcount <= pwdata[6:0];
      end
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          kcnt       <= '0;
          best_found <= 1'b0;
        end
        ST_INIT: begin
          if (kcnt == (VB+1)'(MAX_VERTICES - 1)) begin
            kcnt <= '0;
          end else begin
            kcnt <= kcnt + 1'b1;
          end
        end
        ST_RELAX: begin
          if (kcnt == (VB+1)'(MAX_VERTICES)) begin
            kcnt       <= '0;
            best_found <= 1'b0;
          end else begin
            kcnt <= kcnt + 1'b1;
            if (pick) begin
              best_found <= 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (adv) begin
            kcnt <= (kcnt == (VB+1)'(MAX_VERTICES - 1)) ? '0 : kcnt + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      a_r   <= src_vertex;
      b_r   <= dst_vertex;
      start <= src_vertex;
      dir_r <= directed;
      w_r   <= directed ? WEIGHT_BITS'(edge_weight) : WEIGHT_BITS'(1);
    end
    if (state == ST_INIT) begin
      cur      <= start[VB-1:0];
      cur_dist <= '0;
    end
    if (state == ST_RELAX) begin
      if (kcnt == (VB+1)'(MAX_VERTICES)) begin
        cur      <= pick ? jm1[VB-1:0] : best_idx;
        cur_dist <= pick ? upd.dist_val : best_dist;
      end else if (pick) begin
        best_idx  <= jm1[VB-1:0];
        best_dist <= upd.dist_val;
      end
    end
    if (out_load) begin
      vertex_index  <= 6'(kcnt);
      path_distance <= head.reached ? head.dist_val : '0;
      parent_vertex <= has_parent ? head.parent : '0;
      parent_valid  <= has_parent;
      reachable     <= head.reached;
      last_flag     <= (7'(kcnt) == nv - 7'd1);
    end
  end

  // the ram is only read, never written, while the ring is relaxed
  a_relax_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_RELAX |-> !ram_we) else $error("edge ram written during relax");

  a_cur_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RELAX |-> 7'(cur) < nv) else $error("current vertex out of range");

  // settled distances never decrease
  a_monotone: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RELAX && kcnt == (VB+1)'(MAX_VERTICES) && best_found)
      |-> best_dist >= cur_dist) else $error("picked distance below current");

  a_load_in_out: assert property (@(posedge clk) disable iff (rst)
    out_load |-> state == ST_OUT && (!result_valid || result_ready))
    else $error("result word loaded over a pending word");

endmodule
